// File: src/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64_pkg;

   // codec_mode register codes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // special characters
   localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;   // '+'
   localparam logic [7:0] SLASH_CHAR = 8'h2F;   // '/'

   // results one request can cause
   localparam int unsigned MAX_RESULTS = 4;

   // results of one request, handed from the core to the serialiser
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] chars;   // entry 0 goes out first
      logic [2:0]                  count;   // 0..4 results
      logic                        data;    // 0 for an empty end marker
      logic                        last;    // final entry closes the message
      logic                        error;   // error flag of the final entry
   } bundle_type;

   // six-bit value to alphabet character
   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26)       r = 8'h41 + {2'b00, v};
      else if (v < 6'd52)  r = 8'h61 + {2'b00, v - 6'd26};
      else if (v < 6'd62)  r = 8'h30 + {2'b00, v - 6'd52};
      else if (v == 6'd62) r = PLUS_CHAR;
      else                 r = SLASH_CHAR;
      return r;
   endfunction

   // character to {invalid, six-bit value}
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      logic [6:0] r;
      if (c >= 8'h41 && c <= 8'h5A)      r = {1'b0, 6'(c - 8'h41)};
      else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
      else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
      else if (c == PLUS_CHAR)           r = {1'b0, 6'd62};
      else if (c == SLASH_CHAR)          r = {1'b0, 6'd63};
      else                               r = {1'b1, 6'd0};
      return r;
   endfunction

endpackage

// File: src/b64_req_if.sv
// ----------------------------------------------------------------------------
// b64_req_if
// Request channel: one data byte or character per request.
// ----------------------------------------------------------------------------
interface b64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: src/b64_rsp_if.sv
// ----------------------------------------------------------------------------
// b64_rsp_if
// Result channel: one character or decoded byte per result.
// ----------------------------------------------------------------------------
interface b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       out_last;
   logic       out_error;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   output out_error, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_last,
                   input out_error, output ready);
endinterface

// File: src/b64_core.sv
// ----------------------------------------------------------------------------
// b64_core
// Message state and single-pass encode/decode of one accepted request into a
// bundle of up to four results.
// ----------------------------------------------------------------------------
module b64_core
   import b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output bundle_type bundle
);

   logic        mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  held_ff, held_in;
   logic        pad_ff, pad_in;
   logic        bad_ff, bad_in;

   logic [23:0] group;
   logic        full_group;
   logic [6:0]  dec;
   logic [15:0] acc_sh;
   logic [3:0]  bits;
   logic [2:0]  rem;

   // next state and results of the presented request
   always_comb begin
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      held_in    = held_ff;
      pad_in     = pad_ff;
      bad_in     = bad_ff;
      bundle     = '0;
      group      = {acc_ff, in_byte};
      full_group = 1'b0;
      dec        = char_to_sextet(in_byte);
      acc_sh     = {acc_ff[9:0], dec[5:0]};
      bits       = {1'b0, held_ff} + 4'd6;
      rem        = 3'(bits - 4'd8);

      if (mode_ff == MODE_ENCODE) begin
         // gather three bytes, emit four characters
         if (held_ff >= 3'd2) begin
            full_group      = 1'b1;
            bundle.chars[0] = sextet_to_char(group[23:18]);
            bundle.chars[1] = sextet_to_char(group[17:12]);
            bundle.chars[2] = sextet_to_char(group[11:6]);
            bundle.chars[3] = sextet_to_char(group[5:0]);
            bundle.count    = 3'd4;
            bundle.data     = 1'b1;
            acc_in          = '0;
            held_in         = '0;
         end else begin
            acc_in  = {acc_ff[7:0], in_byte};
            held_in = held_ff + 3'd1;
         end
         // flush leftover bytes with padding
         if (in_last) begin
            bundle.last  = 1'b1;
            bundle.count = 3'd4;
            bundle.data  = 1'b1;
            if (!full_group) begin
               if (held_ff == 3'd0) begin
                  bundle.chars[0] = sextet_to_char(in_byte[7:2]);
                  bundle.chars[1] = sextet_to_char({in_byte[1:0], 4'b0000});
                  bundle.chars[2] = PAD_CHAR;
                  bundle.chars[3] = PAD_CHAR;
               end else begin
                  bundle.chars[0] = sextet_to_char(acc_in[15:10]);
                  bundle.chars[1] = sextet_to_char(acc_in[9:4]);
                  bundle.chars[2] = sextet_to_char({acc_in[3:0], 2'b00});
                  bundle.chars[3] = PAD_CHAR;
               end
            end
         end
      end else begin
         // shift six bits in, emit a byte once eight have gathered
         if (!pad_ff && !bad_ff) begin
            if (in_byte == PAD_CHAR) begin
               pad_in = 1'b1;
            end else if (dec[6]) begin
               bad_in = 1'b1;
            end else if (bits >= 4'd8) begin
               bundle.chars[0] = 8'(acc_sh >> rem);
               bundle.count    = 3'd1;
               bundle.data     = 1'b1;
               acc_in          = acc_sh & ((16'd1 << rem) - 16'd1);
               held_in         = rem;
            end else begin
               acc_in  = acc_sh;
               held_in = bits[2:0];
            end
         end
         // close the message, empty marker if nothing came out
         if (in_last) begin
            bundle.last  = 1'b1;
            bundle.error = bad_in;
            if (bundle.count == 3'd0) begin
               bundle.count = 3'd1;
               bundle.data  = 1'b0;
            end
         end
      end

      if (in_last) begin
         acc_in  = '0;
         held_in = '0;
         pad_in  = 1'b0;
         bad_in  = 1'b0;
      end

      if (!accept) begin
         acc_in  = acc_ff;
         held_in = held_ff;
         pad_in  = pad_ff;
         bad_in  = bad_ff;
      end

      // a mode write drops the message in flight
      if (csr_write_enable) begin
         mode_in = csr_write_data;
         acc_in  = '0;
         held_in = '0;
         pad_in  = 1'b0;
         bad_in  = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
         acc_ff  <= '0;
         held_ff <= '0;
         pad_ff  <= 1'b0;
         bad_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         held_ff <= held_in;
         pad_ff  <= pad_in;
         bad_ff  <= bad_in;
      end
   end

   // encode holds at most two bytes
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ENCODE) |-> (held_ff <= 3'd2))
      else $error("b64_core: encode holds more than two bytes");

   // decode holds an even bit count below eight
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DECODE) |-> (held_ff[0] == 1'b0 && held_ff <= 3'd6))
      else $error("b64_core: odd or oversized decode bit count");

   // a last request leaves clean message state
   assert property (@(posedge clock) disable iff (reset)
      (accept && in_last) |=> (held_ff == 3'd0 && !pad_ff && !bad_ff && acc_ff == 16'd0))
      else $error("b64_core: message state not cleared after last request");

endmodule

// File: src/b64_serialiser.sv
// ----------------------------------------------------------------------------
// b64_serialiser
// Result register: holds one bundle, sends an entry per cycle while ready.
// ----------------------------------------------------------------------------
module b64_serialiser
   import b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   output logic       load_ready,
   input  bundle_type bundle,
   b64_rsp_if.source  rsp_bus
);

   bundle_type  hold_ff, hold_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  index_ff, index_in;

   logic        final_entry;
   logic        taken;
   logic        load;

   assign final_entry = ({1'b0, index_ff} + 3'd1) == count_ff;
   assign taken       = rsp_bus.valid && rsp_bus.ready;
   assign load_ready  = (count_ff == 3'd0) || (taken && final_entry);
   assign load        = load_valid && load_ready && (bundle.count != 3'd0);

   // result entry on show
   assign rsp_bus.valid     = count_ff != 3'd0;
   assign rsp_bus.out_byte  = hold_ff.data ? hold_ff.chars[index_ff] : 8'd0;
   assign rsp_bus.out_valid = hold_ff.data;
   assign rsp_bus.out_last  = hold_ff.last && final_entry;
   assign rsp_bus.out_error = hold_ff.error && final_entry;

   // next bundle and position
   always_comb begin
      hold_in  = hold_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (load) begin
         hold_in  = bundle;
         count_in = bundle.count;
         index_in = '0;
      end else if (taken) begin
         if (final_entry) begin
            count_in = '0;
            index_in = '0;
         end else begin
            index_in = index_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
      hold_ff <= hold_in;
   end

   // position stays inside the bundle
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != 3'd0) |-> ({1'b0, index_ff} < count_ff))
      else $error("b64_serialiser: index beyond bundle");

   // error only on the closing result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.out_error) |-> rsp_bus.out_last)
      else $error("b64_serialiser: error flag on a non-final result");

   // an empty marker is a lone closing result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.out_valid) |-> (rsp_bus.out_last && count_ff == 3'd1))
      else $error("b64_serialiser: malformed empty marker");

   // final entry taken with nothing new leaves the register empty
   assert property (@(posedge clock) disable iff (reset)
      (taken && final_entry && !load) |=> (count_ff == 3'd0))
      else $error("b64_serialiser: bundle not retired");

endmodule

// File: src/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 codec (standard alphabet, '=' padding) over a byte stream, with the
// direction chosen by a one-bit mode register.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  req_bus   in         valid / ready       in_byte[7:0], in_last
//  rsp_bus   out        valid / ready       out_byte[7:0], out_valid, out_last,
//                                           out_error
//  csr       in         csr_write_enable    csr_write_data (codec_mode)
//
//  A request is processed in the cycle it is accepted; its results (up to four)
//  leave the result register one per cycle from the next cycle on, while
//  rsp_bus is ready. A request is taken while the result register is empty or
//  its final entry is being taken, so in encoding the four characters of a
//  group hold the single result register and the next request is accepted
//  with the last one; decoding takes one request a cycle unless stalled.
//  Requests that cause no result leave the result register untouched.
//  Reset (synchronous) selects encode and clears all message state; a mode
//  write also clears message state.
//  A stalled result holds the current entry and blocks every request.
// ----------------------------------------------------------------------------
module base64_stream_codec
   import b64_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   b64_req_if.sink   req_bus,
   b64_rsp_if.source rsp_bus
);

   bundle_type bundle;
   logic       load_ready;
   logic       accept;

   assign req_bus.ready = load_ready;
   assign accept        = req_bus.valid && load_ready;

   // state and per-request computation
   b64_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .in_byte          (req_bus.in_byte),
      .in_last          (req_bus.in_last),
      .bundle           (bundle)
   );

   // result register and output sequencing
   b64_serialiser u_serialiser (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_bus.valid),
      .load_ready (load_ready),
      .bundle     (bundle),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: dv/b64_transcode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64_transcode_checker
// Watches the request, result and register ports of the base64 codec, works
// out the characters or bytes each accepted request must produce, and
// compares every accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module b64_transcode_checker
   import b64_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic csr_write_data,
   b64_req_if   req_mon,
   b64_rsp_if   rsp_mon,
   output int   error_count,
   output int   outstanding
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic       out_error;
   } codec_result_type;

   localparam string ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // predicted codec state
   logic          codec_mode;
   logic [15:0]   held_bits;
   logic [2:0]    held_count;
   logic          pad_seen;
   logic          bad_seen;

   codec_result_type expected_out[$];
   codec_result_type step_out[4];
   int               step_n;
   int               shown;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      return ALPHABET[v];
   endfunction

   // {invalid, value} by search of the alphabet
   function automatic logic [6:0] char_sextet(input logic [7:0] c);
      logic [6:0] r;
      r = 7'h40;
      for (int i = 0; i < 64; i++) begin
         if (ALPHABET[i] == c) r = {1'b0, 6'(i)};
      end
      return r;
   endfunction

   task automatic clear_message();
      held_bits  = '0;
      held_count = '0;
      pad_seen   = 1'b0;
      bad_seen   = 1'b0;
   endtask

   task automatic emit(input logic [7:0] b, input logic v, input logic l, input logic e);
      step_out[step_n] = '{b, v, l, e};
      step_n++;
   endtask

   // encode: three bytes in, four characters out; flush with padding on last
   task automatic encode_step(input logic [7:0] b, input logic l);
      logic [23:0] grp;
      step_n = 0;
      if (held_count >= 3'd2) begin
         grp = {held_bits, b};
         emit(sextet_char(grp[23:18]), 1'b1, 1'b0, 1'b0);
         emit(sextet_char(grp[17:12]), 1'b1, 1'b0, 1'b0);
         emit(sextet_char(grp[11:6]),  1'b1, 1'b0, 1'b0);
         emit(sextet_char(grp[5:0]),   1'b1, 1'b0, 1'b0);
         held_bits  = '0;
         held_count = '0;
      end else begin
         held_bits  = {held_bits[7:0], b};
         held_count = held_count + 3'd1;
      end
      if (l) begin
         if (held_count == 3'd1) begin
            grp = {held_bits[7:0], 16'h0000};
            emit(sextet_char(grp[23:18]), 1'b1, 1'b0, 1'b0);
            emit(sextet_char(grp[17:12]), 1'b1, 1'b0, 1'b0);
            emit(PAD_CHAR, 1'b1, 1'b0, 1'b0);
            emit(PAD_CHAR, 1'b1, 1'b1, 1'b0);
         end else if (held_count == 3'd2) begin
            grp = {held_bits, 8'h00};
            emit(sextet_char(grp[23:18]), 1'b1, 1'b0, 1'b0);
            emit(sextet_char(grp[17:12]), 1'b1, 1'b0, 1'b0);
            emit(sextet_char(grp[11:6]),  1'b1, 1'b0, 1'b0);
            emit(PAD_CHAR, 1'b1, 1'b1, 1'b0);
         end else begin
            // full group just left: its final character closes the message
            step_out[step_n-1].out_last = 1'b1;
         end
         clear_message();
      end
   endtask

   // decode: six bits per character, a byte whenever eight have gathered
   task automatic decode_step(input logic [7:0] b, input logic l);
      logic [6:0]  code;
      logic [21:0] wide;
      logic [15:0] bits16;
      int          nbits;
      step_n = 0;
      if (!pad_seen && !bad_seen) begin
         if (b == PAD_CHAR) begin
            pad_seen = 1'b1;
         end else begin
            code = char_sextet(b);
            if (code[6]) begin
               bad_seen = 1'b1;
            end else begin
               wide   = {held_bits, code[5:0]};
               bits16 = wide[15:0];
               nbits  = int'(held_count) + 6;
               if (nbits >= 8) begin
                  nbits -= 8;
                  emit(8'(bits16 >> nbits), 1'b1, 1'b0, 1'b0);
                  bits16 = bits16 & ((16'd1 << nbits) - 16'd1);
               end
               held_bits  = bits16;
               held_count = 3'(nbits);
            end
         end
      end
      if (l) begin
         if (step_n > 0) begin
            step_out[0].out_last  = 1'b1;
            step_out[0].out_error = bad_seen;
         end else begin
            emit(8'h00, 1'b0, 1'b1, bad_seen);
         end
         clear_message();
      end
   endtask

   // compare taken results first, then book what new requests owe
   always @(posedge clock) begin
      codec_result_type got;
      codec_result_type want;
      if (reset) begin
         codec_mode = MODE_ENCODE;
         clear_message();
         expected_out.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.out_byte, rsp_mon.out_valid, rsp_mon.out_last,
                    rsp_mon.out_error};
            if (expected_out.size() == 0) begin
               error_count++;
               if (shown < 10) begin
                  shown++;
                  $display("%0t: unexpected result byte %02h valid %0b last %0b error %0b",
                           $time, got.out_byte, got.out_valid, got.out_last,
                           got.out_error);
               end
            end else begin
               want = expected_out.pop_front();
               if (got != want) begin
                  error_count++;
                  if (shown < 10) begin
                     shown++;
                     $display("%0t: result mismatch: ", $time,
                              "expected byte %02h valid %0b last %0b error %0b, ",
                              want.out_byte, want.out_valid, want.out_last,
                              want.out_error,
                              "got byte %02h valid %0b last %0b error %0b",
                              got.out_byte, got.out_valid, got.out_last,
                              got.out_error);
                  end
               end
            end
         end
         // a mode write drops any message in progress
         if (csr_write_enable) begin
            codec_mode = csr_write_data;
            clear_message();
         end
         if (req_mon.valid && req_mon.ready) begin
            if (codec_mode == MODE_ENCODE) encode_step(req_mon.in_byte, req_mon.in_last);
            else                           decode_step(req_mon.in_byte, req_mon.in_last);
            for (int k = 0; k < step_n; k++) expected_out = {expected_out, step_out[k]};
         end
      end
      outstanding = expected_out.size();
   end

endmodule

// File: dv/tb_base64_stream_codec.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_codec
// Drives the base64 codec with directed and random messages in both modes,
// under bursty requests and a stalling result side; the checker beside the
// block predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_base64_stream_codec
   import b64_pkg::*;
();

   localparam int    CYCLE_LIMIT = 400000;
   localparam int    ITEM_TARGET = 500;
   localparam string ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTS} stall_style_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;
   int   error_count;
   int   outstanding;
   int   cycle_count = 0;
   int   burst_left;
   int   counted_items;
   logic [7:0] msg_bytes[$];

   stall_style_type stall_style = STALL_NONE;
   int              window_left = 0;
   int              stall_left  = 0;

   b64_req_if req_bus();
   b64_rsp_if rsp_bus();

   base64_stream_codec DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   b64_transcode_checker transcode_chk (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: stall style changes from window to window
   always @(negedge clock) begin
      if (window_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         window_left = $urandom_range(16, 96);
      end
      window_left--;
      case (stall_style)
         STALL_NONE:  rsp_bus.ready <= 1'b1;
         STALL_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         STALL_HEAVY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_left > 0) begin
               rsp_bus.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_bus.ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(3, 12);
            end
         end
      endcase
   end

   function automatic bit is_b64(input logic [7:0] c);
      bit hit;
      hit = 0;
      for (int i = 0; i < 64; i++) begin
         if (ALPHABET[i] == c) hit = 1;
      end
      return hit;
   endfunction

   function automatic logic [7:0] rand_b64();
      return ALPHABET[$urandom_range(0, 63)];
   endfunction

   function automatic logic [7:0] rand_bad_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (is_b64(c) || c == PAD_CHAR) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // called and returning on a falling edge
   task automatic write_mode(input logic m);
      csr_write_data   <= m;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // one request; valid stays high into the next request unless a gap is due
   task automatic send_request(input logic [7:0] b, input logic l);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= l;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // sends msg_bytes; ignored characters after '=' or a bad one are not counted
   task automatic send_message(input bit cut, input bit decoding);
      bit skip;
      skip = 0;
      for (int i = 0; i < msg_bytes.size(); i++) begin
         send_request(msg_bytes[i], !cut && (i == msg_bytes.size() - 1));
         if (!skip) counted_items++;
         if (decoding && (msg_bytes[i] == PAD_CHAR || !is_b64(msg_bytes[i]))) skip = 1;
      end
   endtask

   // hold requests until every owed result is in, then let the block settle
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic load_text(input string s);
      msg_bytes.delete();
      for (int i = 0; i < s.len(); i++) msg_bytes = {msg_bytes, s[i]};
   endtask

   task automatic build_raw_msg();
      int len;
      msg_bytes.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 9);
      repeat (len) msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
   endtask

   // mostly well-formed text, some broken, some pure noise
   task automatic build_text_msg();
      int pick;
      int groups;
      int tail;
      msg_bytes.delete();
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         groups = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
         repeat (groups * 4) msg_bytes = {msg_bytes, rand_b64()};
         tail = $urandom_range(0, 3);
         if (tail == 1) begin
            repeat (2) msg_bytes = {msg_bytes, rand_b64()};
            if ($urandom_range(0, 7) != 0) repeat (2) msg_bytes = {msg_bytes, PAD_CHAR};
         end else if (tail == 2) begin
            repeat (3) msg_bytes = {msg_bytes, rand_b64()};
            if ($urandom_range(0, 7) != 0) msg_bytes = {msg_bytes, PAD_CHAR};
         end else if (tail == 3 || msg_bytes.size() == 0) begin
            repeat ($urandom_range(1, 4)) msg_bytes = {msg_bytes, rand_b64()};
         end
         // junk at the end, after any padding
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
         end
         // broken message: one bad character somewhere
         if (pick == 7) msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = rand_bad_char();
      end else begin
         repeat ($urandom_range(1, 8)) msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
      end
   endtask

   initial begin
      bit decoding;
      bit cut;
      int phase_end;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.in_byte  = 8'h00;
      req_bus.in_last  = 1'b0;
      rsp_bus.ready    = 1'b0;
      burst_left       = 0;
      counted_items    = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // encode: one and two leftover bytes, a full group of '+', extremes
      msg_bytes = '{8'h00};
      send_message(0, 0);
      msg_bytes = '{8'hFF, 8'hFF};
      send_message(0, 0);
      msg_bytes = '{8'hFB, 8'hEF, 8'hBE};
      send_message(0, 0);
      // message cut by a mode write, then a fresh one
      msg_bytes = '{8'h41};
      send_message(1, 0);
      settle();
      write_mode(MODE_ENCODE);
      msg_bytes = '{8'h80};
      send_message(0, 0);
      settle();

      // decode: padding with ignored tail, bad character, empty end marker
      write_mode(MODE_DECODE);
      load_text("QQ=*Z");
      send_message(0, 1);
      load_text("T*W");
      send_message(0, 1);
      load_text("A");
      send_message(0, 1);
      load_text("+/9z");
      send_message(0, 1);
      msg_bytes = '{8'hFF};
      send_message(0, 1);
      msg_bytes = '{8'h00};
      send_message(0, 1);
      settle();

      // random phases, each under a fresh mode write
      while (counted_items < ITEM_TARGET) begin
         decoding = $urandom_range(0, 1);
         write_mode(decoding ? MODE_DECODE : MODE_ENCODE);
         phase_end = counted_items + $urandom_range(20, 80);
         while (counted_items < phase_end && counted_items < ITEM_TARGET) begin
            if (decoding) build_text_msg();
            else          build_raw_msg();
            cut = ($urandom_range(0, 24) == 0);
            send_message(cut, decoding);
            if (cut) break;
            if ($urandom_range(0, 9) == 0) settle();
         end
         settle();
      end

      repeat (10) @(negedge clock);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else                  $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
src/b64_pkg.sv
src/b64_req_if.sv
src/b64_rsp_if.sv
src/b64_core.sv
src/b64_serialiser.sv
src/base64_stream_codec.sv
dv/b64_transcode_checker.sv
dv/tb_base64_stream_codec.sv
